// ===== rtl/lir_pkg.sv =====
// Shared types and constants of the linear interpolation resampler.
package lir_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned STEP_W    = 36;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned CHAN_W    = 3;
  localparam int unsigned FRAC_W    = 32;
  localparam int unsigned RESULT_W  = 7;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 64;

  localparam int unsigned MAX_RESULTS = 64;

  localparam logic [STEP_W-1:0] STEP_MIN   = 36'h0_2000_0000;
  localparam logic [STEP_W-1:0] STEP_RESET = 36'h1_0000_0000;
  localparam logic [STEP_W:0]   ONE_FRAME  = 37'h0_1_0000_0000;

  // Register select, taken from paddr bit 3 (8-byte spacing)
  localparam logic REG_STEP  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EMIT = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_COPY = 4'b1000
  } lir_state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic              last;
  } lir_tag_t;

endpackage

// ===== rtl/linear_interp_resampler_core.sv =====
// Top level of the linear interpolation resampler: sequencer, config registers, output stage.
//
//  channel   dir  beat                               handshake
//  --------  ---  ---------------------------------  -----------------------------
//  input     in   sample_i, start_req_i              in_valid_i / in_stall_o
//  output    out  out_sample_o, channel_o,           out_valid_o / out_stall_i
//                 last_of_run_o
//  config    in   APB, 64-bit data, regs at 0x0/0x8   psel/penable/pwrite, pready=1
//
// A beat that does not complete a frame is only stored. A beat that completes a
// frame starts a run of R results (at most 64), R possibly 0: the interpolator
// emits one result per cycle while the output does not stall, stage 1 drains,
// then the current frame is copied into the previous-frame memory one entry per
// cycle over the single read port of the current-frame memory.
// Reset clears the frame valid bits, phase and sequencer at once; no sweep.
// A stall on the output freezes the whole interpolation pipeline and holds back
// emission and the drain of stage 1; new input beats are taken as soon as the copy
// is done, while results may still wait.
module linear_interp_resampler_core #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lir_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                           start_req_i,
  // output stream
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lir_pkg::SAMPLE_W-1:0]   out_sample_o,
  output logic [lir_pkg::CHAN_W-1:0]     channel_o,
  output logic                           last_of_run_o,
  // config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lir_pkg::PADDR_W-1:0]    paddr,
  input  logic [lir_pkg::PDATA_W-1:0]    pwdata,
  output logic [lir_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import lir_pkg::*;

  localparam int unsigned CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);

  // ---------------- configuration registers ----------------
  logic [STEP_W-1:0]  step_ratio_q;
  logic [COUNT_W-1:0] channel_count_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ratio_q    <= STEP_RESET;
      channel_count_q <= COUNT_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_STEP:  step_ratio_q    <= pwdata[STEP_W-1:0];
        REG_COUNT: channel_count_q <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_STEP:  prdata = PDATA_W'(step_ratio_q);
      REG_COUNT: prdata = PDATA_W'(channel_count_q);
      default:   prdata = '0;
    endcase
  end

  // Effective (clamped) settings
  logic [COUNT_W-1:0] nch;
  logic [STEP_W-1:0]  step_eff;

  always_comb begin
    if (channel_count_q == '0) begin
      nch = COUNT_W'(1);
    end else if (channel_count_q > COUNT_W'(MAX_CHANNELS)) begin
      nch = COUNT_W'(MAX_CHANNELS);
    end else begin
      nch = channel_count_q;
    end
  end

  assign step_eff = (step_ratio_q < STEP_MIN) ? STEP_MIN : step_ratio_q;

  // ---------------- sequencer state ----------------
  lir_state_e          state_q, state_d;
  logic [CH_W-1:0]     pos_q, pos_d;        // channel slot of next input sample
  logic                have_first_q, have_first_d;
  logic [STEP_W-1:0]   phase_q, phase_d;    // 4.32 phase
  logic [CH_W-1:0]     ch_q, ch_d;          // channel being issued
  logic [RESULT_W-1:0] n_q, n_d;            // results issued in this run
  logic [CNT_W-1:0]    cp_idx_q, cp_idx_d;  // copy sweep read index
  logic                cp_wr_q, cp_wr_d;
  logic [CH_W-1:0]     cp_wr_idx_q, cp_wr_idx_d;

  logic                in_acc;
  logic                adv;                 // pipeline advance
  logic                issue;
  logic                issue_last;
  logic                cp_rd;
  logic                s1_vld_q;

  logic [CH_W-1:0]     pos_eff;
  logic [CH_W:0]       pos_inc;
  logic [STEP_W-1:0]   phase_eff;
  logic                hf_eff;
  logic [STEP_W:0]     phase_nx;
  logic [RESULT_W-1:0] n_nx;
  logic                ch_at_end;
  logic                more;
  logic                out_vld_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign adv        = !out_vld_q || !out_stall_i;
  assign issue      = (state_q == ST_EMIT) && adv;
  assign cp_rd      = (state_q == ST_COPY) && (cp_idx_q < CNT_W'(MAX_CHANNELS));

  // Start request clears phase, slot and first-frame flag ahead of the sample
  assign pos_eff   = start_req_i ? '0 : pos_q;
  assign phase_eff = start_req_i ? '0 : phase_q;
  assign hf_eff    = start_req_i ? 1'b0 : have_first_q;
  assign pos_inc   = {1'b0, pos_eff} + (CH_W+1)'(1);

  assign phase_nx  = {1'b0, phase_q} + {1'b0, step_eff};
  assign n_nx      = n_q + RESULT_W'(1);
  assign ch_at_end = (5'(ch_q) == (5'(nch) - 5'd1));
  // next position exists while phase stays inside the frame and results fit
  assign more      = (phase_nx[STEP_W:FRAC_W] == '0)
                  && ((8'(n_nx) + 8'(nch)) <= 8'(MAX_RESULTS));
  assign issue_last = ch_at_end && !more;

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    have_first_d = have_first_q;
    phase_d      = phase_q;
    ch_d         = ch_q;
    n_d          = n_q;
    cp_idx_d     = cp_idx_q;
    cp_wr_d      = 1'b0;
    cp_wr_idx_d  = cp_wr_idx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          phase_d      = phase_eff;
          have_first_d = hf_eff;
          if (5'(pos_inc) < 5'(nch)) begin
            pos_d = pos_inc[CH_W-1:0];
          end else begin
            // frame complete
            pos_d = '0;
            if (!hf_eff) begin
              have_first_d = 1'b1;
              state_d      = ST_WAIT;
            end else if (phase_eff[STEP_W-1:FRAC_W] != '0) begin
              phase_d = phase_eff - ONE_FRAME[STEP_W-1:0];
              state_d = ST_WAIT;
            end else begin
              ch_d    = '0;
              n_d     = '0;
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          n_d = n_nx;
          if (ch_at_end) begin
            ch_d = '0;
            if (more) begin
              phase_d = phase_nx[STEP_W-1:0];
            end else begin
              phase_d = phase_nx[STEP_W-1:0] - ONE_FRAME[STEP_W-1:0];
              state_d = ST_WAIT;
            end
          end else begin
            ch_d = ch_q + CH_W'(1);
          end
        end
      end
      ST_WAIT: begin
        // copy reuses the current-frame read port: stage 1 must be empty
        cp_idx_d = '0;
        if (!s1_vld_q) begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        if (cp_rd) begin
          cp_idx_d    = cp_idx_q + CNT_W'(1);
          cp_wr_d     = 1'b1;
          cp_wr_idx_d = cp_idx_q[CH_W-1:0];
        end
        if (cp_wr_q && (cp_wr_idx_q == CH_W'(MAX_CHANNELS - 1))) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      have_first_q <= 1'b0;
      phase_q      <= '0;
      ch_q         <= '0;
      n_q          <= '0;
      cp_idx_q     <= '0;
      cp_wr_q      <= 1'b0;
      cp_wr_idx_q  <= '0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      have_first_q <= have_first_d;
      phase_q      <= phase_d;
      ch_q         <= ch_d;
      n_q          <= n_d;
      cp_idx_q     <= cp_idx_d;
      cp_wr_q      <= cp_wr_d;
      cp_wr_idx_q  <= cp_wr_idx_d;
    end
  end

  // ---------------- frame memories ----------------
  logic [SAMPLE_W-1:0] cur_rd, prev_rd;
  logic [CH_W-1:0]     cur_rd_addr;

  assign cur_rd_addr = (state_q == ST_COPY) ? cp_idx_q[CH_W-1:0] : ch_q;

  lir_frame_mem #(
    .DEPTH (MAX_CHANNELS),
    .AW    (CH_W)
  ) u_cur_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (in_acc && start_req_i),
    .wr_en_i   (in_acc),
    .wr_addr_i (pos_eff),
    .wr_data_i (sample_i),
    .rd_en_i   (issue || cp_rd),
    .rd_addr_i (cur_rd_addr),
    .rd_data_o (cur_rd)
  );

  lir_frame_mem #(
    .DEPTH (MAX_CHANNELS),
    .AW    (CH_W)
  ) u_prev_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (in_acc && start_req_i),
    .wr_en_i   (cp_wr_q),
    .wr_addr_i (cp_wr_idx_q),
    .wr_data_i (cur_rd),
    .rd_en_i   (issue),
    .rd_addr_i (ch_q),
    .rd_data_o (prev_rd)
  );

  // ---------------- interpolation pipeline ----------------
  // stage 1: memory read data, with fraction and tag carried alongside
  logic [FRAC_W-1:0] frac_s1_q;
  lir_tag_t          tag_s1_q;
  logic              ip_vld;
  logic [SAMPLE_W-1:0] ip_res;
  lir_tag_t          ip_tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      frac_s1_q     <= phase_q[FRAC_W-1:0];
      tag_s1_q.chan <= CHAN_W'(ch_q);
      tag_s1_q.last <= issue_last;
    end
  end

  lir_interp u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s1_vld_q),
    .prev_i (prev_rd),
    .cur_i  (cur_rd),
    .frac_i (frac_s1_q),
    .tag_i  (tag_s1_q),
    .vld_o  (ip_vld),
    .res_o  (ip_res),
    .tag_o  (ip_tag)
  );

  // output register
  logic [SAMPLE_W-1:0] out_sample_q;
  lir_tag_t            out_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= ip_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && ip_vld) begin
      out_sample_q <= ip_res;
      out_tag_q    <= ip_tag;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_sample_o  = out_sample_q;
  assign channel_o     = out_tag_q.chan;
  assign last_of_run_o = out_tag_q.last;

  // ---------------- assertions ----------------
  // the copy sweep must never overwrite read data still held in stage 1
  a_copy_s1_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> !s1_vld_q)
    else $error("copy sweep overlaps pending interpolation read");

  // the final result of a run ends emission
  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && issue_last) |=> (state_q == ST_WAIT))
    else $error("emission continued after last result");

  // a run never exceeds the result limit
  a_run_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (n_q < RESULT_W'(MAX_RESULTS)))
    else $error("run exceeded result limit");

endmodule

// ===== rtl/lir_frame_mem.sv =====
// Frame store: synchronous 1R1W memory with per-entry valid bits (invalid reads as zero).
module lir_frame_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic                          wr_en_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [lir_pkg::SAMPLE_W-1:0]  wr_data_i,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  output logic [lir_pkg::SAMPLE_W-1:0]  rd_data_o
);
  import lir_pkg::*;

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rd_q;
  logic [DEPTH-1:0]    vld_q, vld_d;
  logic                rd_vld_q;

  always_comb begin
    vld_d = vld_q;
    if (clr_i) begin
      vld_d = '0;
    end
    if (wr_en_i) begin
      vld_d[wr_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/lir_interp.sv =====
// Interpolation datapath: registered (cur-prev)*frac, then round half up and add.
module lir_interp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [lir_pkg::SAMPLE_W-1:0]  prev_i,
  input  logic [lir_pkg::SAMPLE_W-1:0]  cur_i,
  input  logic [lir_pkg::FRAC_W-1:0]    frac_i,
  input  lir_pkg::lir_tag_t             tag_i,
  output logic                          vld_o,
  output logic [lir_pkg::SAMPLE_W-1:0]  res_o,
  output lir_pkg::lir_tag_t             tag_o
);
  import lir_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_W + 1 + FRAC_W + 1;

  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [PROD_W-1:0]   rnd;
  logic [SAMPLE_W-1:0]        base_q;
  lir_tag_t                   tag_q;
  logic                       vld_q;

  assign diff   = $signed({cur_i[SAMPLE_W-1], cur_i}) - $signed({prev_i[SAMPLE_W-1], prev_i});
  // 17 x 33 bit signed product, operands sign-extended to the product width
  assign prod_d = PROD_W'(diff) * PROD_W'($signed({1'b0, frac_i}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && vld_i) begin
      prod_q <= prod_d;
      base_q <= prev_i;
      tag_q  <= tag_i;
    end
  end

  // floor((p + 2^31) / 2^32); result is convex so low 16 bits suffice
  assign rnd   = prod_q + $signed(PROD_W'(64'h8000_0000));
  assign res_o = base_q + rnd[FRAC_W +: SAMPLE_W];
  assign vld_o = vld_q;
  assign tag_o = tag_q;

endmodule
